>>> design/cht_pkg.sv
// cht_pkg: shared sizes, result codes and controller/datapath interface types
package cht_pkg;

  // table geometry
  localparam int unsigned BUCKET_BITS     = 9;
  localparam int unsigned CHAIN_LIMIT     = 16;
  localparam int unsigned NODE_POOL_DEPTH = 8192;

  localparam int unsigned NUM_BUCKETS = 1 << BUCKET_BITS;
  // node index, and link = node index plus one (zero means none)
  localparam int unsigned IDX_W  = $clog2(NODE_POOL_DEPTH);
  localparam int unsigned CNT_W  = $clog2(NODE_POOL_DEPTH + 1);
  localparam int unsigned LINK_W = CNT_W;

  // refuse a new key when 5 * (count + 1) >= 4 * buckets * chain limit
  localparam int unsigned LOAD_NUM   = 4 * NUM_BUCKETS * CHAIN_LIMIT;
  localparam int unsigned FULL_COUNT = (LOAD_NUM + 4) / 5 - 1;

  // word field widths and offsets
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned TAG_LO = 0;
  localparam int unsigned KEY_LO = TAG_LO + TAG_W;
  localparam int unsigned VAL_LO = KEY_LO + KEY_W;
  localparam int unsigned DATA_W = VAL_LO + VAL_W;

  // request kinds
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [2:0] {
    RC_INSERTED  = 3'd0,
    RC_UPDATED   = 3'd1,
    RC_FOUND     = 3'd2,
    RC_FULL      = 3'd3,
    RC_NOT_FOUND = 3'd4
  } res_code_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;        // latch request, read bucket head
    logic      clr_wr;        // clear one bucket head
    logic      head_chk;      // head data valid, read first node
    logic      node_chk;      // node data valid
    logic      node_adv;      // follow next link, read that node
    logic      set_code;      // load result code and value
    res_code_t code;
    logic      val_from_node; // result value from node memory
    logic      upd_wr;        // overwrite value of matched node
    logic      ins_wr;        // write new node, head if bucket empty
    logic      link_wr;       // link new node after head, bump count
    logic      out_load;      // move result into output register
  } cht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic head_empty;
    logic hit;
    logic tail;
    logic full;
    logic op_get;
    logic out_free;
  } cht_stat_t;

endpackage

>>> design/cht_dp.sv
// cht_dp: request registers, bucket and node memories, result and output registers
module cht_dp
  import cht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cht_cmd_t          cmd,
  output cht_stat_t         st,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic [2:0]        out_tuser
);

  // memories
  logic [LINK_W-1:0] bucket_head [NUM_BUCKETS];
  logic [KEY_W-1:0]  node_key    [NODE_POOL_DEPTH];
  logic [VAL_W-1:0]  node_value  [NODE_POOL_DEPTH];
  logic [LINK_W-1:0] node_next   [NODE_POOL_DEPTH];

  // registered read data
  logic [LINK_W-1:0] head_q;
  logic [KEY_W-1:0]  nkey_q;
  logic [VAL_W-1:0]  nval_q;
  logic [LINK_W-1:0] nnext_q;

  // request and walk registers
  logic              op_r;
  logic [TAG_W-1:0]  tag_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] head_next_r;
  logic [LINK_W-1:0] link_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BUCKET_BITS-1:0] clr_cnt_r;

  // result and output registers
  res_code_t         res_code_r;
  logic [VAL_W-1:0]  res_val_r;
  logic              out_valid_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [VAL_W-1:0]  out_val_r;
  res_code_t         out_code_r;

  logic [BUCKET_BITS-1:0] in_bucket;
  logic [BUCKET_BITS-1:0] key_bucket;
  logic [LINK_W-1:0]      new_link;
  logic [IDX_W-1:0]       cnt_idx;
  logic [IDX_W-1:0]       node_raddr;
  logic                   node_re;

  logic                   bh_we;
  logic [BUCKET_BITS-1:0] bh_waddr;
  logic [LINK_W-1:0]      bh_wdata;
  logic                   nv_we;
  logic [IDX_W-1:0]       nv_waddr;
  logic                   nn_we;
  logic [IDX_W-1:0]       nn_waddr;
  logic [LINK_W-1:0]      nn_wdata;

  assign in_bucket  = in_tdata[KEY_LO +: BUCKET_BITS];
  assign key_bucket = key_r[BUCKET_BITS-1:0];
  assign new_link   = cnt_r + CNT_W'(1);
  assign cnt_idx    = cnt_r[IDX_W-1:0];

  // node read address: first node from head, later nodes from next link
  assign node_re    = cmd.head_chk | cmd.node_adv;
  assign node_raddr = cmd.head_chk ? IDX_W'(head_q - LINK_W'(1))
                                   : IDX_W'(nnext_q - LINK_W'(1));

  // bucket head write port: clearing pass or new head
  always_comb begin
    bh_we    = cmd.clr_wr | (cmd.ins_wr & (head_r == '0));
    bh_waddr = cmd.clr_wr ? clr_cnt_r : key_bucket;
    bh_wdata = cmd.clr_wr ? '0 : new_link;
  end

  // node value write port: update in place or new node
  assign nv_we    = cmd.upd_wr | cmd.ins_wr;
  assign nv_waddr = cmd.upd_wr ? IDX_W'(link_r - LINK_W'(1)) : cnt_idx;

  // node next write port: new node's link or head's link to new node
  always_comb begin
    nn_we    = cmd.ins_wr | (cmd.link_wr & (head_r != '0));
    nn_waddr = cmd.ins_wr ? cnt_idx : IDX_W'(head_r - LINK_W'(1));
    if (cmd.ins_wr) begin
      nn_wdata = (head_r == '0) ? '0 : head_next_r;
    end else begin
      nn_wdata = new_link;
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (bh_we) begin
      bucket_head[bh_waddr] <= bh_wdata;
    end
    if (cmd.accept) begin
      head_q <= bucket_head[in_bucket];
    end
  end

  // node key memory
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      node_key[cnt_idx] <= key_r;
    end
    if (node_re) begin
      nkey_q <= node_key[node_raddr];
    end
  end

  // node value memory
  always_ff @(posedge clk) begin
    if (nv_we) begin
      node_value[nv_waddr] <= val_r;
    end
    if (node_re) begin
      nval_q <= node_value[node_raddr];
    end
  end

  // node next memory
  always_ff @(posedge clk) begin
    if (nn_we) begin
      node_next[nn_waddr] <= nn_wdata;
    end
    if (node_re) begin
      nnext_q <= node_next[node_raddr];
    end
  end

  // request, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tuser;
      tag_r <= in_tdata[TAG_LO +: TAG_W];
      key_r <= in_tdata[KEY_LO +: KEY_W];
      val_r <= in_tdata[VAL_LO +: VAL_W];
    end
    if (cmd.head_chk) begin
      head_r <= head_q;
      link_r <= head_q;
    end
    if (cmd.node_chk && link_r == head_r) begin
      head_next_r <= nnext_q;
    end
    if (cmd.node_adv) begin
      link_r <= nnext_q;
    end
    if (cmd.set_code) begin
      res_code_r <= cmd.code;
      res_val_r  <= cmd.val_from_node ? nval_q : val_r;
    end
  end

  // entry count and clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.link_wr) begin
        cnt_r <= new_link;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + BUCKET_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tag_r  <= tag_r;
      out_key_r  <= key_r;
      out_val_r  <= res_val_r;
      out_code_r <= res_code_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_key_r, out_tag_r};
  assign out_tuser  = out_code_r;

  // status to controller
  always_comb begin
    st.clr_done   = &clr_cnt_r;
    st.head_empty = (head_q == '0);
    st.hit        = (nkey_q == key_r);
    st.tail       = (nnext_q == '0);
    st.full       = (32'(cnt_r) >= FULL_COUNT) || (32'(cnt_r) >= NODE_POOL_DEPTH);
    st.op_get     = (op_r == OP_GET);
    st.out_free   = !out_valid_r || out_tready;
  end

endmodule

>>> design/cht_ctrl.sv
// cht_ctrl: request sequencer for clearing, chain walk, insert and result hand-off
module cht_ctrl
  import cht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  cht_stat_t st,
  output cht_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_NODE,
    S_INS_NODE,
    S_INS_LINK,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;
  logic   walk_miss;

  // key not in chain: empty bucket or end of chain reached
  assign walk_miss = (state_r == S_HEAD && st.head_empty) ||
                     (state_r == S_NODE && !st.hit && st.tail);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_chk = 1'b1;
        if (!st.head_empty) begin
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        cmd.node_chk = 1'b1;
        if (st.hit) begin
          cmd.set_code = 1'b1;
          state_nxt    = S_DONE;
          if (st.op_get) begin
            cmd.code          = RC_FOUND;
            cmd.val_from_node = 1'b1;
          end else begin
            cmd.code   = RC_UPDATED;
            cmd.upd_wr = 1'b1;
          end
        end else if (!st.tail) begin
          cmd.node_adv = 1'b1;
        end
      end
      S_INS_NODE: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // miss resolution: not found, refused, or insert
    if (walk_miss) begin
      cmd.set_code = 1'b1;
      priority if (st.op_get) begin
        cmd.code  = RC_NOT_FOUND;
        state_nxt = S_DONE;
      end else if (st.full) begin
        cmd.code  = RC_FULL;
        state_nxt = S_DONE;
      end else begin
        cmd.code  = RC_INSERTED;
        state_nxt = S_INS_NODE;
      end
    end
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

>>> design/chained_hash_table_put_get.sv
// chained_hash_table_put_get: chained hash table top, put and get one request at a time
//
// channel  dir  handshake              tdata                        tuser
// in_      in   in_tvalid/in_tready    request_tag, key, value      operation
// out_     out  out_tvalid/out_tready  tag_out, key_out, value_out  result_code
//
// a request reads its bucket head, then walks the chain one node memory read per
// cycle until a match or the chain end; an insert then writes the node and links it
// after reset a clearing pass empties the 2^BUCKET_BITS bucket heads, and
// in_tready stays low until it ends
// a finished result waits in the output register while the next request runs;
// a request's result holds in the controller only when that register is full
module chained_hash_table_put_get
  import cht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // request_tag, key, value
  input  logic              in_tuser,   // operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // tag_out, key_out, value_out
  output logic [2:0]        out_tuser   // result_code
);

  cht_cmd_t  cmd;
  cht_stat_t st;

  // sequencer
  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // memories and registers
  cht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // one request in flight: ready drops right after an accepted word
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a node is only taken while the table is below its load limit
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !st.full)
    else $error("node inserted into full table");

  // a result never overwrites one still waiting downstream
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

endmodule

>>> tb/sv/chained_hash_table_put_get_tb.sv
// chained_hash_table_put_get_tb: self-checking testbench for the chained hash table
module chained_hash_table_put_get_tb;
  import cht_pkg::*;

  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned NUM_CODES     = 5;
  localparam int unsigned MAX_REPORTS   = 10;

  // one expected result word
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    res_code_t        code;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;     // request_tag, key, value
  logic              in_tuser = OP_PUT; // operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;         // tag_out, key_out, value_out
  logic [2:0]        out_tuser;         // result_code

  // shadow of the table contents
  logic [VAL_W-1:0] stored_value [logic [KEY_W-1:0]];
  logic [KEY_W-1:0] known_keys [$];
  int unsigned      entry_total = 0;

  table_result_t awaited_results [$];
  int unsigned   fault_count = 0;
  int unsigned   checked_count = 0;
  int unsigned   code_tally [NUM_CODES];
  int unsigned   cycle_count = 0;

  // idling controls
  logic src_idle = 1'b0;
  logic sink_idle = 1'b0;
  logic sink_hold = 1'b0;

  chained_hash_table_put_get dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // load threshold or pool exhaustion refuses a new key
  function automatic bit table_is_full();
    return (5 * (longint'(entry_total) + 1) >= longint'(LOAD_NUM)) ||
           (entry_total >= NODE_POOL_DEPTH);
  endfunction

  // apply one request to the shadow table and return its result word
  function automatic table_result_t apply_request(logic op, logic [TAG_W-1:0] tag,
                                                  logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] value);
    table_result_t r;
    r.tag   = tag;
    r.key   = key;
    r.value = value;
    if (op == OP_GET) begin
      if (stored_value.exists(key)) begin
        r.value = stored_value[key];
        r.code  = RC_FOUND;
      end else begin
        r.code = RC_NOT_FOUND;
      end
    end else if (stored_value.exists(key)) begin
      stored_value[key] = value;
      r.code = RC_UPDATED;
    end else if (table_is_full()) begin
      r.code = RC_FULL;
    end else begin
      stored_value[key] = value;
      known_keys.push_back(key);
      entry_total++;
      r.code = RC_INSERTED;
    end
    return r;
  endfunction

  function automatic void note_fault(string msg);
    if (fault_count < MAX_REPORTS) $display("%0t: %s", $time, msg);
    fault_count++;
  endfunction

  // offer one request word and wait for its handshake
  task automatic send_request(logic op, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] value);
    int unsigned gap;
    logic [DATA_W-1:0] word;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    word = '0;
    word[TAG_LO +: TAG_W] = tag;
    word[KEY_LO +: KEY_W] = key;
    word[VAL_LO +: VAL_W] = value;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    awaited_results.push_back(apply_request(op, tag, key, value));
  endtask

  // random request: mostly known keys and crowded buckets so chains get walked
  task automatic send_random_request();
    logic op;
    logic [KEY_W-1:0] key;
    int unsigned pick;
    int unsigned hot;
    op   = ($urandom_range(0, 1) == 0) ? OP_PUT : OP_GET;
    pick = $urandom_range(0, 9);
    key  = {$urandom, $urandom};
    if (pick < 4 && known_keys.size() > 0) begin
      key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else if (pick < 6) begin
      hot = $urandom_range(0, 3) * 97 + 11;
      key[BUCKET_BITS-1:0] = BUCKET_BITS'(hot);
    end
    send_request(op, $urandom, key, {$urandom, $urandom});
  endtask

  // check each result word against the oldest expectation
  task automatic check_result();
    table_result_t want;
    logic [TAG_W-1:0] got_tag;
    logic [KEY_W-1:0] got_key;
    logic [VAL_W-1:0] got_value;
    got_tag   = out_tdata[TAG_LO +: TAG_W];
    got_key   = out_tdata[KEY_LO +: KEY_W];
    got_value = out_tdata[VAL_LO +: VAL_W];
    if (awaited_results.size() == 0) begin
      note_fault($sformatf("unexpected word: tag %h key %h value %h code %0d",
                           got_tag, got_key, got_value, out_tuser));
    end else begin
      want = awaited_results.pop_front();
      checked_count++;
      if (got_tag !== want.tag || got_key !== want.key || got_value !== want.value ||
          out_tuser !== want.code) begin
        note_fault($sformatf({"mismatch: expected tag %h key %h value %h code %0d,",
                              " actual tag %h key %h value %h code %0d"},
                             want.tag, want.key, want.value, want.code,
                             got_tag, got_key, got_value, out_tuser));
      end else begin
        code_tally[want.code]++;
      end
    end
  endtask

  // receiver: random stalls per word, plus the long hold-off
  initial begin : result_sink
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_result();
        gap_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end else if (gap_left > 0) begin
        gap_left--;
      end
      out_tready <= rst_n && (gap_left == 0) && !sink_hold;
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             awaited_results.size());
    $display("tb: failure");
    $finish;
  end

  // extremes, chain positions, update and miss cases
  task automatic test_directed_cases();
    logic [KEY_W-1:0] ones;
    logic [KEY_W-1:0] chain_a;
    logic [KEY_W-1:0] chain_b;
    logic [KEY_W-1:0] chain_c;
    ones    = '1;
    chain_a = 64'h0000_0000_0000_0155;
    chain_b = 64'h1000_0000_0000_0155;
    chain_c = 64'hFFFF_FFFF_FFFF_FF55;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    // empty table, then both key extremes
    send_request(OP_GET, 32'h0000_0000, '0, ones);
    send_request(OP_PUT, 32'hFFFF_FFFF, '0, ones);
    send_request(OP_PUT, 32'h0000_0001, ones, '0);
    send_request(OP_GET, 32'h8000_0000, '0, 64'h5555_5555_5555_5555);
    send_request(OP_GET, 32'h7FFF_FFFF, ones, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_PUT, 32'h0000_0002, '0, 64'h0123_4567_89AB_CDEF);
    send_request(OP_GET, 32'h0000_0003, '0, '0);
    // three keys in one bucket: head, then inserts right after the head
    send_request(OP_PUT, 32'h0000_0010, chain_a, 64'h0000_0000_0000_00AA);
    send_request(OP_PUT, 32'h0000_0011, chain_b, 64'h0000_0000_0000_00BB);
    send_request(OP_PUT, 32'h0000_0012, chain_c, 64'h0000_0000_0000_00CC);
    send_request(OP_GET, 32'h0000_0013, chain_b, '0);
    send_request(OP_GET, 32'h0000_0014, chain_c, '0);
    send_request(OP_GET, 32'h0000_0015, chain_a, '0);
    // miss after walking the full chain
    send_request(OP_GET, 32'h0000_0016, 64'h2000_0000_0000_0155, 64'hDEAD_BEEF_0000_0001);
    send_request(OP_PUT, 32'h0000_0017, chain_b, ones);
    send_request(OP_GET, 32'h0000_0018, chain_b, '0);
    send_request(OP_GET, 32'h0000_0019, 64'h8000_0000_0000_0000, 64'hFEED_0000_0000_0002);
  endtask

  // random mix in blocks, every combination of sender and receiver idling
  task automatic test_random_mix();
    int unsigned blk;
    int unsigned i;
    for (blk = 0; blk < 9; blk++) begin
      src_idle  = blk[0];
      sink_idle = blk[1];
      for (i = 0; i < 100; i++) send_random_request();
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    int unsigned i;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    for (i = 0; i < 40; i++) send_random_request();
  endtask

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_mix();
    test_output_backpressure();
    // drain, then allow for any stray word
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d results checked in %0d cycles, table ended with %0d entries",
             checked_count, cycle_count, entry_total);
    $display("summary: inserted %0d, updated %0d, found %0d, refused full %0d, not found %0d",
             code_tally[RC_INSERTED], code_tally[RC_UPDATED], code_tally[RC_FOUND],
             code_tally[RC_FULL], code_tally[RC_NOT_FOUND]);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d faults", fault_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/cht_pkg.sv
design/cht_dp.sv
design/cht_ctrl.sv
design/chained_hash_table_put_get.sv
tb/sv/chained_hash_table_put_get_tb.sv
